// ----- hdl/bitmap_block_allocator_top_macros.svh -----
// Assertion macros for the bitmap block allocator top level.
// Expects clk and rst in the scope of the including module.
`ifndef BITMAP_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define BBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/bba_pkg.sv -----
// Shared types and constants of the bitmap block allocator.
// No dependencies.
`default_nettype none

package bba_pkg;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FREE  = 2'd3;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic load_scan;
    logic load_check;
    logic scan;
    logic check;
  } bba_cmd_t;

  typedef struct packed {
    logic out_free;
    logic found;
    logic last;
  } bba_sts_t;

endpackage

`default_nettype wire

// ----- hdl/bba_channels.sv -----
// Valid/ready channel interfaces for request and response words.
// No dependencies.
`default_nettype none

interface bba_req_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [6:0] block_address;

  modport source (output valid, output mode, output block_address, input ready);
  modport sink   (input valid, input mode, input block_address, output ready);
endinterface

interface bba_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [5:0] block_number;
  logic [6:0] cylinder_code;

  modport source (output valid, output status, output block_number,
                  output cylinder_code, input ready);
  modport sink   (input valid, input status, input block_number,
                  input cylinder_code, output ready);
endinterface

`default_nettype wire

// ----- hdl/bba_ctrl.sv -----
// Controller FSM of the bitmap block allocator: sequences scan and check.
// Depends on bba_pkg.
`default_nettype none

module bba_ctrl
  import bba_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire logic     in_mode,
  output logic          in_ready,
  input  wire bba_sts_t sts,
  output bba_cmd_t      cmd
);

  typedef enum logic [1:0] {IDLE, SCAN, CHECK} state_t;

  state_t state;

  assign in_ready = (state == IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load_scan  = (in_mode == MODE_ALLOC);
          cmd.load_check = (in_mode == MODE_FREE);
        end
      end
      SCAN:    cmd.scan  = sts.out_free;
      CHECK:   cmd.check = sts.out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid) state <= (in_mode == MODE_ALLOC) ? SCAN : CHECK;
        end
        SCAN: begin
          if (sts.out_free && (sts.found || sts.last)) state <= IDLE;
        end
        CHECK: begin
          if (sts.out_free) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/bba_datapath.sv -----
// Datapath: bitmap registers, byte index, first-clear search, result register.
// Depends on bba_pkg.
`default_nettype none

module bba_datapath
  import bba_pkg::*;
#(
  parameter int MAP_BYTES = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire bba_cmd_t   cmd,
  output bba_sts_t        sts,
  input  wire logic [6:0] in_block_address,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_status,
  output logic [5:0]      out_block_number,
  output logic [6:0]      out_cylinder_code
);

  localparam int IDX_W = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam logic [IDX_W:0] DEPTH   = (IDX_W + 1)'(MAP_BYTES);
  localparam logic [3:0]     MAP_LIM = 4'(MAP_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAP_BYTES - 1);

  logic [7:0]       usage_map [MAP_BYTES];
  logic [IDX_W-1:0] idx;
  logic [3:0]       abyte;
  logic [2:0]       apos;

  logic [7:0] rd_byte;
  logic       zero_found;
  logic [2:0] zpos;
  logic [2:0] idx3;
  logic       in_range;
  logic       out_free;

  assign rd_byte  = ({1'b0, idx} < DEPTH) ? usage_map[idx] : 8'h00;
  assign in_range = (abyte < MAP_LIM);
  assign out_free = !out_valid || out_ready;
  assign idx3     = 3'(idx);

  // first clear bit, msb first
  always_comb begin
    zero_found = 1'b0;
    zpos       = 3'd0;
    for (int p = 7; p >= 0; p--) begin
      if (!rd_byte[7 - p]) begin
        zero_found = 1'b1;
        zpos       = 3'(p);
      end
    end
  end

  assign sts.out_free = out_free;
  assign sts.found    = zero_found;
  assign sts.last     = (idx == LAST_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int b = 0; b < MAP_BYTES; b++) usage_map[b] <= 8'h00;
    end else begin
      if ((cmd.scan && (zero_found || sts.last)) || cmd.check) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.scan && zero_found) begin
        usage_map[idx][3'd7 - zpos] <= 1'b1;
      end
      if (cmd.check) begin
        if (in_range && rd_byte[3'd7 - apos]) usage_map[idx][3'd7 - apos] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_scan) idx <= '0;
    if (cmd.load_check) begin
      abyte <= in_block_address[6:3];
      apos  <= in_block_address[2:0];
      idx   <= in_block_address[IDX_W+2:3];
    end
    if (cmd.scan) begin
      if (zero_found) begin
        out_status        <= ST_OK;
        out_block_number  <= {idx3, zpos};
        out_cylinder_code <= 7'({idx3, 3'b000}) + 7'({idx3, 1'b0}) + 7'(zpos);
      end else if (sts.last) begin
        out_status        <= ST_FULL;
        out_block_number  <= '0;
        out_cylinder_code <= '0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
    if (cmd.check) begin
      out_block_number  <= '0;
      out_cylinder_code <= '0;
      if (!in_range)                    out_status <= ST_RANGE;
      else if (!rd_byte[3'd7 - apos])   out_status <= ST_FREE;
      else                              out_status <= ST_OK;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/bitmap_block_allocator_top.sv -----
// Top level of the bitmap block allocator: controller plus datapath.
// Depends on bba_pkg, bba_channels, bba_ctrl, bba_datapath and the macro header.
//
//   channel  dir  word fields
//   req      in   mode, block_address
//   rsp      out  status, block_number, cylinder_code
//
// Allocate: accepted in IDLE, then SCAN searches the bitmap byte by byte. Free:
// accepted in IDLE, then CHECK tests the addressed bit. The scan loop reads one
// byte of the bitmap registers a cycle unless stalled. Reset clears the bitmap
// to all free at once. A result waits in the output register; the next word is
// taken meanwhile; the scan or check stalls only while that register is full.
`default_nettype none

`include "bitmap_block_allocator_top_macros.svh"

module bitmap_block_allocator_top
  import bba_pkg::*;
#(
  parameter int MAP_BYTES = 8
) (
  input wire logic clk,
  input wire logic rst,
  bba_req_if.sink  req,
  bba_rsp_if.source rsp
);

  bba_cmd_t cmd;
  bba_sts_t sts;
  logic     ctl_ready;

  assign req.ready = ctl_ready;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_mode  (req.mode),
    .in_ready (ctl_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bba_datapath #(.MAP_BYTES(MAP_BYTES)) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .in_block_address  (req.block_address),
    .out_valid         (rsp.valid),
    .out_ready         (rsp.ready),
    .out_status        (rsp.status),
    .out_block_number  (rsp.block_number),
    .out_cylinder_code (rsp.cylinder_code)
  );

  `BBA_ASSERT_NOW(a_scan_slot, cmd.scan || cmd.check, sts.out_free, "work with output full")
  `BBA_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "ready after accept")
  `BBA_ASSERT_NEXT(a_check_result, cmd.check, rsp.valid, "free gave no result")
  `BBA_ASSERT_NEXT(a_scan_result, cmd.scan && (sts.found || sts.last), rsp.valid, "scan lost result")

endmodule

`default_nettype wire
